// ----- rtl/prq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the pixel quantizer / run encoder
// Holds the register indexes, channel mode codes, counter limits and the
// job word passed from the classifying front end to the run encoder.
// ----------------------------------------------------------------------------
package prq_pkg;

  // configuration register indexes
  localparam logic CFG_QUANT_LEVELS = 1'b0;
  localparam logic CFG_CHANNEL_MODE = 1'b1;

  // channel mode codes; every other code behaves as grey
  localparam logic [2:0] MODE_RED   = 3'd0;
  localparam logic [2:0] MODE_GREEN = 3'd1;
  localparam logic [2:0] MODE_BLUE  = 3'd2;
  localparam logic [2:0] MODE_ALL   = 3'd3;
  localparam logic [2:0] MODE_GREY  = 3'd4;

  localparam int LEVELS_W = 6;
  localparam int MODE_W   = 3;
  localparam int PIX_W    = 8;
  localparam int SYM_W    = 5;
  localparam int RUN_LEN_W = 16;

  localparam logic [LEVELS_W-1:0] LEVELS_MIN   = 6'd4;
  localparam logic [LEVELS_W-1:0] LEVELS_MAX   = 6'd32;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 6'd16;

  // divide-by-three reciprocal: floor(s * 683 / 2048) == floor(s / 3) for s < 768
  localparam int SUM_W     = PIX_W + 2;
  localparam int RECIP_W   = 10;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 10'd683;
  localparam int RECIP_SHIFT = 11;

  // run counter
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // job queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one classified pixel: up to three symbols in feed order
  typedef struct packed {
    logic [2:0][SYM_W-1:0] sym;
    logic                  three;  // all three symbols are fed, else only sym[0]
    logic                  last;   // flush the open run after the symbols
  } job_t;

endpackage

// ----- rtl/prq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_front: pixel intake and quantizer
// Registers each pixel with its channel selection (and grey average), then
// quantizes the selected channels and pushes one job word to the queue.
// ----------------------------------------------------------------------------
module prq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [prq_pkg::LEVELS_W-1:0]   quant_levels,
  input  logic [prq_pkg::MODE_W-1:0]     channel_mode,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic [prq_pkg::PIX_W-1:0]      red,
  input  logic [prq_pkg::PIX_W-1:0]      green,
  input  logic [prq_pkg::PIX_W-1:0]      blue,
  input  logic                           last_pixel,
  output logic                           job_wr,
  output prq_pkg::job_t                  job,
  input  logic                           q_full
);

  localparam int PROD_W = prq_pkg::PIX_W + prq_pkg::LEVELS_W;
  localparam int AVG_W  = prq_pkg::SUM_W + prq_pkg::RECIP_W;

  logic                                s1_v_r;
  logic [2:0][prq_pkg::PIX_W-1:0]      s1_val_r;
  logic                                s1_three_r;
  logic                                s1_last_r;

  logic [2:0][prq_pkg::PIX_W-1:0]      sel_val;
  logic                                sel_three;
  logic [prq_pkg::SUM_W-1:0]           sum;
  logic [AVG_W-1:0]                    avg_prod;
  logic [prq_pkg::PIX_W-1:0]           grey;
  logic [prq_pkg::LEVELS_W-1:0]        lv;
  logic [2:0][PROD_W-1:0]              prod;

  assign sum = prq_pkg::SUM_W'(red) + prq_pkg::SUM_W'(green) + prq_pkg::SUM_W'(blue);
  assign avg_prod = AVG_W'(sum) * AVG_W'(prq_pkg::RECIP_THIRD);
  assign grey = avg_prod[prq_pkg::RECIP_SHIFT +: prq_pkg::PIX_W];

  always_comb begin
    sel_val   = '0;
    sel_three = 1'b0;
    unique case (channel_mode)
      prq_pkg::MODE_RED:   sel_val[0] = red;
      prq_pkg::MODE_GREEN: sel_val[0] = green;
      prq_pkg::MODE_BLUE:  sel_val[0] = blue;
      prq_pkg::MODE_ALL: begin
        sel_val   = {blue, green, red};
        sel_three = 1'b1;
      end
      default:             sel_val[0] = grey;  // grey and unused codes
    endcase
  end

  // stage 1 advances when empty or when its job enters the queue
  assign job_wr    = s1_v_r && !q_full;
  assign pix_ready = !s1_v_r || job_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pix_ready) begin
      s1_v_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      s1_val_r   <= sel_val;
      s1_three_r <= sel_three;
      s1_last_r  <= last_pixel;
    end
  end

  // clamp the level count so every symbol fits in five bits
  always_comb begin
    if (quant_levels < prq_pkg::LEVELS_MIN) begin
      lv = prq_pkg::LEVELS_MIN;
    end else if (quant_levels > prq_pkg::LEVELS_MAX) begin
      lv = prq_pkg::LEVELS_MAX;
    end else begin
      lv = quant_levels;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]    = PROD_W'(s1_val_r[i]) * PROD_W'(lv);
      job.sym[i] = prod[i][prq_pkg::PIX_W +: prq_pkg::SYM_W];
    end
    job.three = s1_three_r;
    job.last  = s1_last_r;
  end

endmodule

// ----- rtl/prq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_queue: job queue between front end and run encoder
// Small register FIFO; write and read may happen in the same cycle.
// ----------------------------------------------------------------------------
module prq_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  prq_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd,
  output logic          rd_valid,
  output prq_pkg::job_t rd_job
);

  prq_pkg::job_t                   mem_r [prq_pkg::QDEPTH];
  logic [prq_pkg::QAW-1:0]         wptr_r;
  logic [prq_pkg::QAW-1:0]         rptr_r;
  logic [prq_pkg::QCW-1:0]         cnt_r;
  logic                            do_wr;
  logic                            do_rd;

  assign full     = (cnt_r == prq_pkg::QCW'(prq_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;
  assign rd_job   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

endmodule

// ----- rtl/prq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_back: run-length encoder
// Feeds the head job's symbols into the open run, lists the records it closes
// and sends them through the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module prq_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  prq_pkg::job_t                   q_job,
  output logic                            q_rd,
  output logic                            rec_valid,
  input  logic                            rec_ready,
  output logic [prq_pkg::SYM_W-1:0]       rec_value,
  output logic [prq_pkg::RUN_LEN_W-1:0]   rec_length,
  output logic                            rec_item_last,
  output logic                            rec_image_end
);

  // run state
  logic                               run_open_r;
  logic [prq_pkg::SYM_W-1:0]          open_val_r;
  logic [prq_pkg::COUNT_BITS-1:0]     open_cnt_r;
  logic [1:0]                         idx_r;

  // output register
  logic                               out_v_r;
  logic [prq_pkg::SYM_W-1:0]          out_val_r;
  logic [prq_pkg::RUN_LEN_W-1:0]      out_len_r;
  logic                               out_ilast_r;
  logic                               out_end_r;

  // records of the head job, computed from the current run state
  logic                               op_nxt;
  logic [prq_pkg::SYM_W-1:0]          val_nxt;
  logic [prq_pkg::COUNT_BITS-1:0]     cnt_nxt;
  logic [2:0]                         rec_cnt;
  logic [3:0][prq_pkg::SYM_W-1:0]     rv;
  logic [3:0][prq_pkg::COUNT_BITS-1:0] rl;
  logic [3:0]                         re;
  logic [prq_pkg::SYM_W-1:0]          s;

  logic                               can_load;
  logic                               step;
  logic                               at_last;

  always_comb begin
    op_nxt  = run_open_r;
    val_nxt = open_val_r;
    cnt_nxt = open_cnt_r;
    rec_cnt = '0;
    rv      = '0;
    rl      = '0;
    re      = '0;
    s       = '0;
    for (int i = 0; i < 3; i++) begin
      if (i == 0 || q_job.three) begin
        s = q_job.sym[i];
        if (!op_nxt) begin
          op_nxt  = 1'b1;
          val_nxt = s;
          cnt_nxt = prq_pkg::COUNT_BITS'(1);
        end else if (s == val_nxt && cnt_nxt != prq_pkg::CNT_MAX) begin
          cnt_nxt = cnt_nxt + 1'b1;
        end else begin
          // value change or full counter: close the run
          rv[rec_cnt[1:0]] = val_nxt;
          rl[rec_cnt[1:0]] = cnt_nxt;
          rec_cnt          = rec_cnt + 1'b1;
          val_nxt          = s;
          cnt_nxt          = prq_pkg::COUNT_BITS'(1);
        end
      end
    end
    // last pixel: flush the open run and start the next image afresh
    if (q_job.last) begin
      rv[rec_cnt[1:0]] = val_nxt;
      rl[rec_cnt[1:0]] = cnt_nxt;
      re[rec_cnt[1:0]] = 1'b1;
      rec_cnt          = rec_cnt + 1'b1;
      op_nxt           = 1'b0;
      val_nxt          = '0;
      cnt_nxt          = '0;
    end
  end

  assign can_load = !out_v_r || rec_ready;
  assign step     = q_valid && can_load;
  assign at_last  = (rec_cnt == '0) || (idx_r == 2'(rec_cnt - 3'd1));
  assign q_rd     = step && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      open_val_r <= '0;
      open_cnt_r <= '0;
      idx_r      <= '0;
    end else if (step) begin
      if (at_last) begin
        run_open_r <= op_nxt;
        open_val_r <= val_nxt;
        open_cnt_r <= cnt_nxt;
        idx_r      <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (can_load) begin
      out_v_r <= q_valid && (rec_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (step && rec_cnt != '0) begin
      out_val_r   <= rv[idx_r];
      out_len_r   <= prq_pkg::RUN_LEN_W'(rl[idx_r]);
      out_ilast_r <= at_last;
      out_end_r   <= re[idx_r];
    end
  end

  assign rec_valid     = out_v_r;
  assign rec_value     = out_val_r;
  assign rec_length    = out_len_r;
  assign rec_item_last = out_ilast_r;
  assign rec_image_end = out_end_r;

  // a run is open exactly when its count is nonzero
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r == (open_cnt_r != '0))
    else $error("run open flag and count disagree");

  // the record index stays inside the head job's record list
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (q_valid && rec_cnt > 3'(idx_r)))
    else $error("record index beyond the job's records");

  // an image end record also closes the pixel's record list
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_end_r) |-> out_ilast_r)
    else $error("image end record not marked as last of its pixel");

  // a pending record holds while the sink stalls
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !rec_ready) |=> (out_v_r && $stable(out_val_r) && $stable(out_len_r)))
    else $error("stalled record changed");

endmodule

// ----- rtl/pixel_quantize_rle_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_quantize_rle_encoder: RGB24 pixel quantizer with run-length coding
// Top level: configuration registers, front end, job queue, run encoder.
// ----------------------------------------------------------------------------
// One RGB24 pixel enters per in_ word; the channel mode picks red, green,
// blue, all three (fed red, green, blue in that order) or the grey average
// floor((r+g+b)/3), and each channel value v becomes the symbol
// (v*levels)>>8 with levels clamped to 4..32. Equal symbols collapse into
// runs; a run closes on a value change or when its count reaches 65535, and
// each closed run leaves as one out_ word (value, length). A pixel with
// in_tlast set flushes the open run as a record with out_tlast set, and the
// next pixel starts a new image. out_tuser[0] marks the last record caused
// by a pixel. Pixels are taken one per cycle while the job queue has room;
// the encoder sends the records of a pixel one per cycle through the output
// register while out_tready is high, so the single record port sets the
// sustained rate. A four-entry job queue sits between the one-register
// quantizing front end and the encoder so that a burst of records does not
// stall the pixel source at once. The first record of a pixel passes the
// front-end register, the job queue and the output register before it shows
// on out_tvalid. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module pixel_quantize_rle_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tlast,   // last_pixel
  // run records
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // run_value[4:0], run_length[20:5], zero pad
  output logic [0:0]  out_tuser,  // item_last[0]
  output logic        out_tlast   // image_end
);

  logic [prq_pkg::LEVELS_W-1:0]  quant_levels_r;
  logic [prq_pkg::MODE_W-1:0]    channel_mode_r;

  logic                          job_wr;
  prq_pkg::job_t                 job;
  logic                          q_full;
  logic                          q_rd;
  logic                          q_valid;
  prq_pkg::job_t                 q_job;

  logic [prq_pkg::SYM_W-1:0]     rec_value;
  logic [prq_pkg::RUN_LEN_W-1:0] rec_length;
  logic                          rec_item_last;
  logic                          rec_image_end;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_levels_r <= prq_pkg::LEVELS_RESET;
      channel_mode_r <= prq_pkg::MODE_ALL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prq_pkg::CFG_QUANT_LEVELS: quant_levels_r <= cfg_wdata[prq_pkg::LEVELS_W-1:0];
        prq_pkg::CFG_CHANNEL_MODE: channel_mode_r <= cfg_wdata[prq_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: select channels, average for grey, quantize
  prq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .quant_levels (quant_levels_r),
    .channel_mode (channel_mode_r),
    .pix_valid    (in_tvalid),
    .pix_ready    (in_tready),
    .red          (in_tdata[7:0]),
    .green        (in_tdata[15:8]),
    .blue         (in_tdata[23:16]),
    .last_pixel   (in_tlast),
    .job_wr       (job_wr),
    .job          (job),
    .q_full       (q_full)
  );

  // hold classified pixels while the encoder drains records
  prq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (job_wr),
    .wr_job   (job),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  // back end: run tracking and record output
  prq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .q_rd          (q_rd),
    .rec_valid     (out_tvalid),
    .rec_ready     (out_tready),
    .rec_value     (rec_value),
    .rec_length    (rec_length),
    .rec_item_last (rec_item_last),
    .rec_image_end (rec_image_end)
  );

  // pack the record word
  assign out_tdata = {3'b000, rec_length, rec_value};
  assign out_tuser = rec_item_last;
  assign out_tlast = rec_image_end;

endmodule
